FILE: sv/lzfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lzfd_pkg;

    localparam int HIST_AW        = 13;
    localparam int HIST_DEPTH     = 8192;
    localparam int DATA_W         = 64;
    localparam int COUNT_W        = 4;
    localparam int TOTAL_W        = 20;
    localparam int LEN_W          = 9;
    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CMD_FIFO_AW    = 2;

    typedef enum logic [2:0] {
        PH_CTRL,
        PH_LIT,
        PH_LENX,
        PH_DIST,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERFLOW,
        ST_BAD_REF,
        ST_TRUNC
    } t_status;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_COPY,
        CMD_END
    } t_cmd_kind;

    typedef struct packed {
        logic                 done;
        t_status              status;
        logic [TOTAL_W-1:0]   total;
    } t_info;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [7:0]           lit;
        logic [HIST_AW-1:0]   dst;
        logic [HIST_AW-1:0]   dist_m1;
        logic [LEN_W-1:0]     len;
        t_info                info;
    } t_cmd;

    typedef struct packed {
        logic                 is_lit;
        logic                 is_empty;
        logic                 lastb;
        logic [7:0]           lit;
        logic [HIST_AW-1:0]   dst;
        t_info                info;
    } t_s1;

endpackage
`default_nettype wire

FILE: sv/lzf_stream_decompressor_top.sv
// LZF stream decompressor.
// Compressed bytes enter on the input channel (i_in_valid, o_in_ready), one
// request per byte, with i_in_last on the final byte of a block. Result words
// leave on the output channel (o_out_valid, i_out_ready) carrying up to eight
// bytes, first byte in the lowest lane, with o_out_count valid bytes.
// A parser classifies each byte and writes commands into a four-entry queue;
// a copy engine executes them against an 8192-byte history memory.
// A literal byte leaves as its own word after the queue, the stage-one
// register and the output register. A back-reference of N bytes keeps the
// copy engine busy with one history read and write per cycle unless the output
// stalls, and gives one word per eight bytes; input flows until the queue fills.
// The final result of a block has o_block_done set with o_status and
// o_total_length. The output_limit register lies at address 0 of the APB port.
// Reset clears the parser, the queue, the copy engine and the output register
// and sets the limit to 16384; the history needs no clearing.
// When the receiver stalls, the output word is held and the copy engine and
// then the input side stop once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module lzf_stream_decompressor_top #(
    parameter int WORD_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_in_byte,
    input  logic                              i_in_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lzfd_pkg::DATA_W-1:0]       o_out_data,
    output logic [lzfd_pkg::COUNT_W-1:0]      o_out_count,
    output logic                              o_run_last,
    output logic                              o_block_done,
    output logic [1:0]                        o_status,
    output logic [lzfd_pkg::TOTAL_W-1:0]      o_total_length
);
    import lzfd_pkg::*;

    localparam logic REG_LIMIT = 1'b0;

    logic [TOTAL_W-1:0]   r_limit;
    logic                 w_push;
    logic                 w_full;
    logic                 w_pop;
    logic                 w_empty;
    t_cmd                 w_cmd_in;
    t_cmd                 w_cmd_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIMIT) ? {{(32-TOTAL_W){1'b0}}, r_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= TOTAL_W'(16384);
        end else if (psel && penable && pwrite && paddr[2] == REG_LIMIT) begin
            r_limit <= pwdata[TOTAL_W-1:0];
        end
    end

    lzfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_byte      (i_in_byte),
        .i_last      (i_in_last),
        .i_fifo_full (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    lzfd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty)
    );

    lzfd_back #(
        .WORD_BYTES (WORD_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd_out),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (o_out_data),
        .o_count      (o_out_count),
        .o_run_last   (o_run_last),
        .o_block_done (o_block_done),
        .o_status     (o_status),
        .o_total      (o_total_length)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into a full queue");

    a_done_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_block_done) |-> o_run_last)
        else $error("block end without run end");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_block_done)
        else $error("error status outside block end");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_count <= COUNT_W'(WORD_BYTES)))
        else $error("byte count exceeds word size");

endmodule
`default_nettype wire

FILE: sv/lzfd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lzfd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lzfd_pkg::TOTAL_W-1:0]      i_limit,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_byte,
    input  logic                              i_last,
    input  logic                              i_fifo_full,
    output logic                              o_push,
    output lzfd_pkg::t_cmd                    o_cmd
);
    import lzfd_pkg::*;

    t_phase               r_phase, n_phase;
    logic [TOTAL_W-1:0]   r_pc, n_pc;
    logic [5:0]           r_lit_left, n_lit_left;
    logic [LEN_W-1:0]     r_mlen, n_mlen;
    logic [4:0]           r_dh, n_dh;
    t_status              r_err, n_err;

    logic                 w_accept;
    logic                 w_lit_ctl;
    logic [TOTAL_W:0]     w_lit_sum;
    logic [TOTAL_W:0]     w_copy_sum;
    logic [13:0]          w_dist;
    logic [LEN_W-1:0]     w_total;
    logic                 w_lit_ovf;
    logic                 w_copy_ovf;
    logic                 w_ref_bad;
    logic                 w_emit_lit;
    logic                 w_emit_copy;

    assign w_accept   = i_valid && !i_fifo_full;
    assign o_ready    = !i_fifo_full;
    assign w_lit_ctl  = i_byte inside {[8'd0:8'd31]};
    assign w_lit_sum  = {1'b0, r_pc} + (TOTAL_W+1)'(i_byte[4:0]) + (TOTAL_W+1)'(1);
    assign w_dist     = {1'b0, r_dh, i_byte} + 14'd1;
    assign w_total    = r_mlen + LEN_W'(3);
    assign w_copy_sum = {1'b0, r_pc} + (TOTAL_W+1)'(w_total);
    assign w_lit_ovf  = w_lit_sum > {1'b0, i_limit};
    assign w_copy_ovf = w_copy_sum > {1'b0, i_limit};
    assign w_ref_bad  = TOTAL_W'(w_dist) > r_pc;

    always_comb begin
        n_phase    = r_phase;
        n_pc       = r_pc;
        n_lit_left = r_lit_left;
        n_mlen     = r_mlen;
        n_dh       = r_dh;
        n_err      = r_err;
        case (r_phase)
            PH_CTRL: begin
                if (w_lit_ctl) begin
                    if (w_lit_ovf) begin
                        n_err   = ST_OVERFLOW;
                        n_phase = PH_SKIP;
                    end else begin
                        n_lit_left = 6'(i_byte[4:0]) + 6'd1;
                        n_phase    = PH_LIT;
                    end
                end else begin
                    n_mlen  = LEN_W'(i_byte[7:5]) - LEN_W'(1);
                    n_dh    = i_byte[4:0];
                    n_phase = (i_byte[7:5] == 3'd7) ? PH_LENX : PH_DIST;
                end
            end
            PH_LIT: begin
                n_pc       = r_pc + TOTAL_W'(1);
                n_lit_left = r_lit_left - 6'd1;
                if (r_lit_left == 6'd1) begin
                    n_phase = PH_CTRL;
                end
            end
            PH_LENX: begin
                n_mlen  = r_mlen + LEN_W'(i_byte);
                n_phase = PH_DIST;
            end
            PH_DIST: begin
                if (w_copy_ovf) begin
                    n_err   = ST_OVERFLOW;
                    n_phase = PH_SKIP;
                end else if (w_ref_bad) begin
                    n_err   = ST_BAD_REF;
                    n_phase = PH_SKIP;
                end else begin
                    n_pc    = w_copy_sum[TOTAL_W-1:0];
                    n_phase = PH_CTRL;
                end
            end
            PH_SKIP: begin
                n_phase = PH_SKIP;
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase
        if (i_last && n_err == ST_OK && n_phase != PH_CTRL) begin
            n_err = ST_TRUNC;
        end
    end

    always_comb begin
        w_emit_lit  = (r_phase == PH_LIT);
        w_emit_copy = (r_phase == PH_DIST) && !w_copy_ovf && !w_ref_bad;
        o_push      = w_accept && (w_emit_lit || w_emit_copy || i_last);
        if (w_emit_lit) begin
            o_cmd.kind = CMD_LIT;
        end else if (w_emit_copy) begin
            o_cmd.kind = CMD_COPY;
        end else begin
            o_cmd.kind = CMD_END;
        end
        o_cmd.lit         = i_byte;
        o_cmd.dst         = r_pc[HIST_AW-1:0];
        o_cmd.dist_m1     = {r_dh, i_byte};
        o_cmd.len         = w_total;
        o_cmd.info.done   = i_last;
        o_cmd.info.status = n_err;
        o_cmd.info.total  = n_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CTRL;
            r_pc       <= '0;
            r_lit_left <= '0;
            r_mlen     <= '0;
            r_dh       <= '0;
            r_err      <= ST_OK;
        end else if (w_accept) begin
            if (i_last) begin
                r_phase    <= PH_CTRL;
                r_pc       <= '0;
                r_lit_left <= '0;
                r_mlen     <= '0;
                r_dh       <= '0;
                r_err      <= ST_OK;
            end else begin
                r_phase    <= n_phase;
                r_pc       <= n_pc;
                r_lit_left <= n_lit_left;
                r_mlen     <= n_mlen;
                r_dh       <= n_dh;
                r_err      <= n_err;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/lzfd_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module lzfd_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lzfd_pkg::t_cmd    i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output lzfd_pkg::t_cmd    o_cmd,
    output logic              o_empty
);
    import lzfd_pkg::*;

    t_cmd                     r_mem [CMD_FIFO_DEPTH];
    logic [CMD_FIFO_AW-1:0]   r_wp;
    logic [CMD_FIFO_AW-1:0]   r_rp;
    logic [CMD_FIFO_AW:0]     r_cnt;
    logic                     w_do_push;
    logic                     w_do_pop;

    assign o_full    = (r_cnt == (CMD_FIFO_AW+1)'(CMD_FIFO_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_cmd     = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= r_wp + CMD_FIFO_AW'(1);
            end
            if (w_do_pop) begin
                r_rp <= r_rp + CMD_FIFO_AW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + (CMD_FIFO_AW+1)'(1);
            end else if (!w_do_push && w_do_pop) begin
                r_cnt <= r_cnt - (CMD_FIFO_AW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/lzfd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lzfd_back #(
    parameter int WORD_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lzfd_pkg::t_cmd                    i_cmd,
    input  logic                              i_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [lzfd_pkg::DATA_W-1:0]       o_data,
    output logic [lzfd_pkg::COUNT_W-1:0]      o_count,
    output logic                              o_run_last,
    output logic                              o_block_done,
    output logic [1:0]                        o_status,
    output logic [lzfd_pkg::TOTAL_W-1:0]      o_total
);
    import lzfd_pkg::*;

    localparam int LANE_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

    logic [7:0]               r_hist [HIST_DEPTH];
    logic [7:0]               r_rdata;

    logic [LEN_W-1:0]         r_left;
    logic [HIST_AW-1:0]       r_src;
    logic [HIST_AW-1:0]       r_dst;
    t_info                    r_info;
    logic                     r_s1_valid;
    t_s1                      r_s1;
    logic [DATA_W-1:0]        r_word;
    logic [LANE_W-1:0]        r_lane;

    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_data;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     r_out_run_last;
    logic                     r_out_done;
    t_status                  r_out_status;
    logic [TOTAL_W-1:0]       r_out_total;

    logic                     w_adv;
    logic                     w_busy;
    logic [HIST_AW-1:0]       w_src0;
    logic [HIST_AW-1:0]       w_ra;
    logic                     w_re;
    logic                     w_we;
    logic [7:0]               w_wd;
    logic [DATA_W-1:0]        w_word;
    logic                     w_flush;
    logic                     w_push;

    assign w_adv  = !r_out_valid || i_ready;
    assign w_busy = (r_left != '0);
    assign o_pop  = w_adv && !w_busy && !i_empty;
    assign w_src0 = i_cmd.dst - i_cmd.dist_m1 - HIST_AW'(1);
    assign w_ra   = w_busy ? r_src : w_src0;
    assign w_re   = w_adv && (w_busy || (o_pop && i_cmd.kind == CMD_COPY));
    assign w_we   = w_adv && r_s1_valid && !r_s1.is_empty;
    assign w_wd   = r_s1.is_lit ? r_s1.lit : r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_hist[r_s1.dst] <= w_wd;
        end
        if (w_re) begin
            r_rdata <= (w_we && r_s1.dst == w_ra) ? w_wd : r_hist[w_ra];
        end
    end

    always_comb begin
        w_word = r_word;
        for (int l = 0; l < WORD_BYTES; l++) begin
            if (r_lane == LANE_W'(l)) begin
                w_word[8*l +: 8] = w_wd;
            end
        end
        w_flush = r_s1.is_empty || r_s1.lastb || (r_lane == LANE_W'(WORD_BYTES - 1));
        w_push  = w_adv && r_s1_valid && w_flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_s1_valid  <= 1'b0;
            r_word      <= '0;
            r_lane      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            if (w_busy) begin
                r_s1_valid  <= 1'b1;
                r_s1.is_lit   <= 1'b0;
                r_s1.is_empty <= 1'b0;
                r_s1.lastb    <= (r_left == LEN_W'(1));
                r_s1.dst      <= r_dst;
                r_s1.info     <= r_info;
                r_left      <= r_left - LEN_W'(1);
                r_src       <= r_src + HIST_AW'(1);
                r_dst       <= r_dst + HIST_AW'(1);
            end else if (o_pop) begin
                r_s1_valid    <= 1'b1;
                r_s1.lit      <= i_cmd.lit;
                r_s1.dst      <= i_cmd.dst;
                r_s1.info     <= i_cmd.info;
                case (i_cmd.kind)
                    CMD_LIT: begin
                        r_s1.is_lit   <= 1'b1;
                        r_s1.is_empty <= 1'b0;
                        r_s1.lastb    <= 1'b1;
                    end
                    CMD_COPY: begin
                        r_s1.is_lit   <= 1'b0;
                        r_s1.is_empty <= 1'b0;
                        r_s1.lastb    <= 1'b0;
                        r_left        <= i_cmd.len - LEN_W'(1);
                        r_src         <= w_src0 + HIST_AW'(1);
                        r_dst         <= i_cmd.dst + HIST_AW'(1);
                        r_info        <= i_cmd.info;
                    end
                    default: begin
                        r_s1.is_lit   <= 1'b0;
                        r_s1.is_empty <= 1'b1;
                        r_s1.lastb    <= 1'b1;
                    end
                endcase
            end else begin
                r_s1_valid <= 1'b0;
            end

            r_out_valid <= w_push;
            if (r_s1_valid) begin
                if (w_flush) begin
                    r_word <= '0;
                    r_lane <= '0;
                end else begin
                    r_word <= w_word;
                    r_lane <= r_lane + LANE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_data     <= r_s1.is_empty ? r_word : w_word;
            r_out_count    <= r_s1.is_empty ? '0 : COUNT_W'(r_lane) + COUNT_W'(1);
            r_out_run_last <= r_s1.lastb;
            r_out_done     <= r_s1.lastb && r_s1.info.done;
            r_out_status   <= (r_s1.lastb && r_s1.info.done) ? r_s1.info.status : ST_OK;
            r_out_total    <= (r_s1.lastb && r_s1.info.done) ? r_s1.info.total : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data       = r_out_data;
    assign o_count      = r_out_count;
    assign o_run_last   = r_out_run_last;
    assign o_block_done = r_out_done;
    assign o_status     = r_out_status;
    assign o_total      = r_out_total;

endmodule
`default_nettype wire
